FILE: rtl/core/jsg_pkg.sv
// Shared types, widths and constants of the joint servo governor.
package jsg_pkg;

   localparam int JOINTS_DEFAULT    = 7;
   localparam int FRAC_BITS_DEFAULT = 20;

   localparam int MODE_W      = 2;
   localparam int JOINT_W     = 3;
   localparam int POS_W       = 24;
   localparam int STEP_W      = 21;
   localparam int SPEED_W     = 23;
   localparam int GAIN_W      = 30;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 30;

   // joints from this index on use the narrow integrator clamp band
   localparam int NARROW_BAND_JOINT = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_KEEP    = 2'd0,
      MODE_NEW_REF = 2'd1,
      MODE_HOLD    = 2'd2,
      MODE_RESTART = 2'd3
   } mode_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_GOVERNOR_STEP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_CAP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOLLOW_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_TIME     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SPEED     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CMD_STEP_CAP  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_LOW       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_HIGH      = 3'd7;

   typedef struct packed {
      mode_type                 mode;
      logic [JOINT_W-1:0]       joint_index;
      logic signed [POS_W-1:0]  measured_pos;
      logic signed [POS_W-1:0]  target_ref;
   } req_word_type;

   typedef struct packed {
      logic [JOINT_W-1:0]       out_joint;
      logic signed [POS_W-1:0]  command_pos;
      logic                     command_valid;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    data;
   } csr_word_type;

   typedef struct packed {
      logic [STEP_W-1:0]        governor_step;
      logic [SPEED_W-1:0]       speed_cap;
      logic [GAIN_W-1:0]        follow_gain;
      logic [STEP_W-1:0]        step_time;
      logic [SPEED_W-1:0]       min_speed;
      logic [STEP_W-1:0]        cmd_step_cap;
      logic signed [POS_W-1:0]  pos_low;
      logic signed [POS_W-1:0]  pos_high;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      governor_step: 21'd4027,
      speed_cap:     23'd629146,
      follow_gain:   30'd10485760,
      step_time:     21'd8389,
      min_speed:     23'd5243,
      cmd_step_cap:  21'd20972,
      pos_low:       24'h800000,
      pos_high:      24'h7FFFFF
   };

   typedef struct packed {
      logic signed [POS_W-1:0]  reference;
      logic signed [POS_W-1:0]  governed_target;
      logic signed [POS_W-1:0]  integrator;
   } joint_state_type;

endpackage

FILE: rtl/core/jsg_chan_if.sv
// Valid/ready channel carrying one word per handshake.
interface jsg_chan_if #(
   parameter type word_type = logic
) ();
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

FILE: rtl/core/jsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module jsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/jsg_csr_regs.sv
// Configuration register file of the joint servo governor.
module jsg_csr_regs (
   input  logic            clock,
   input  logic            reset,
   jsg_chan_if.sink        csr_chan,
   output jsg_pkg::cfg_type cfg
);
   import jsg_pkg::*;

   cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.word.index)
            CSR_GOVERNOR_STEP: cfg_ff.governor_step <= csr_chan.word.data[STEP_W-1:0];
            CSR_SPEED_CAP:     cfg_ff.speed_cap     <= csr_chan.word.data[SPEED_W-1:0];
            CSR_FOLLOW_GAIN:   cfg_ff.follow_gain   <= csr_chan.word.data[GAIN_W-1:0];
            CSR_STEP_TIME:     cfg_ff.step_time     <= csr_chan.word.data[STEP_W-1:0];
            CSR_MIN_SPEED:     cfg_ff.min_speed     <= csr_chan.word.data[SPEED_W-1:0];
            CSR_CMD_STEP_CAP:  cfg_ff.cmd_step_cap  <= csr_chan.word.data[STEP_W-1:0];
            CSR_POS_LOW:       cfg_ff.pos_low       <= csr_chan.word.data[POS_W-1:0];
            CSR_POS_HIGH:      cfg_ff.pos_high      <= csr_chan.word.data[POS_W-1:0];
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end
endmodule

FILE: rtl/core/joint_servo_governor_unit.sv
// Top level of the joint servo governor: sequencer, joint state RAM and servo datapath.
//
// One servo tick (word on req_chan) yields one command word on rsp_chan. Per-joint
// reference, governed target and integrator live in one RAM read and written back by a
// sequencer that handles one tick at a time. A tick with an active target runs these
// steps from acceptance to the next acceptance: RAM read, sync and governor step, two
// multiplies with rounding and saturation after each, final clamps with RAM write-back,
// and the output register load. Ticks without an active target and ticks for a joint out
// of range skip the multiplies. The output register frees the input side as soon as it is loaded;
// a stalled rsp_chan holds the sequencer only in its last step. csr_chan accepts a write in
// every cycle and should be used only while no tick is in flight.
module joint_servo_governor_unit #(
   parameter int JOINTS    = jsg_pkg::JOINTS_DEFAULT,
   parameter int FRAC_BITS = jsg_pkg::FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   jsg_chan_if.sink   req_chan,
   jsg_chan_if.source rsp_chan,
   jsg_chan_if.sink   csr_chan
);
   import jsg_pkg::*;

   localparam int AW      = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int JIDX_W  = 5;
   localparam int LIM_W   = ((FRAC_BITS > POS_W) ? FRAC_BITS : POS_W) + 2;
   localparam int ERR_W   = POS_W + 1;
   localparam int PROD1_W = ERR_W + GAIN_W + 1;
   localparam int PROD2_W = POS_W + STEP_W + 1;
   localparam int DEL_W   = STEP_W + 1;
   localparam int SUM_W   = POS_W + 2;

   localparam logic [JIDX_W-1:0] JOINTS_IDX = JIDX_W'(JOINTS);
   localparam logic [JIDX_W-1:0] NARROW_IDX = JIDX_W'(NARROW_BAND_JOINT);

   localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
   localparam longint BAND_WIDE_L   = (ONE_Q * 5 + 50) / 100;
   localparam longint BAND_NARROW_L = (ONE_Q * 2 + 50) / 100;
   localparam logic signed [LIM_W-1:0] BAND_WIDE   = LIM_W'(BAND_WIDE_L);
   localparam logic signed [LIM_W-1:0] BAND_NARROW = LIM_W'(BAND_NARROW_L);

   localparam logic [PROD1_W-1:0] HALF1 = PROD1_W'(1) << (FRAC_BITS - 1);
   localparam logic [PROD2_W-1:0] HALF2 = PROD2_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL1,
      ST_SCALE,
      ST_MUL2,
      ST_FINISH,
      ST_OUT
   } state_type;

   cfg_type cfg;

   jsg_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   state_type               state_ff;
   mode_type                mode_ff;
   logic [JIDX_W-1:0]       joint_ff;
   logic signed [POS_W-1:0] meas_ff;
   logic signed [POS_W-1:0] tref_ff;
   logic [JOINTS-1:0]       synced_ff;
   logic                    active_ff;
   logic                    cmd_ready_ff;
   logic signed [POS_W-1:0] ref_ff;
   logic signed [POS_W-1:0] gt_ff;
   logic signed [POS_W-1:0] integ_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic signed [PROD1_W-1:0] prod1_ff;
   logic signed [POS_W-1:0] qdot_ff;
   logic signed [PROD2_W-1:0] prod2_ff;
   logic signed [POS_W-1:0] res_cmd_ff;
   logic                    res_valid_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   logic                    req_accept;
   logic [JIDX_W-1:0]       req_joint;
   logic [AW-1:0]           addr;
   logic                    in_range;
   logic                    rsp_load;

   logic                    ram_wr_en;
   joint_state_type         ram_wr_state;
   logic                    ram_rd_en;
   logic [$bits(joint_state_type)-1:0] ram_rd_data;
   joint_state_type         ram_rd_state;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_joint  = JIDX_W'(req_chan.word.joint_index);
   assign ram_rd_en  = req_accept && (req_joint < JOINTS_IDX);
   assign addr       = joint_ff[AW-1:0];
   assign in_range   = joint_ff < JOINTS_IDX;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   jsg_ram #(
      .WIDTH ($bits(joint_state_type)),
      .DEPTH (JOINTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr),
      .wr_data (ram_wr_state),
      .rd_en   (ram_rd_en),
      .rd_addr (req_joint[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_state = joint_state_type'(ram_rd_data);

   // tick preparation: restart, sync, reference load, governor step, band clamp
   logic                     restart;
   logic [JOINTS-1:0]        mask_r;
   logic                     unsynced;
   joint_state_type          st_s;
   logic signed [POS_W-1:0]  ref_n;
   logic                     active_n;
   logic                     ready_sync;
   logic                     ready_n;
   logic [JOINTS-1:0]        mask_n;
   logic signed [ERR_W-1:0]  gs_s;
   logic signed [ERR_W-1:0]  gt_diff;
   logic signed [ERR_W-1:0]  gt_move;
   logic signed [ERR_W-1:0]  gt_sum;
   logic signed [POS_W-1:0]  gt_n;
   logic signed [LIM_W-1:0]  band;
   logic signed [LIM_W-1:0]  meas_l;
   logic signed [LIM_W-1:0]  band_lo;
   logic signed [LIM_W-1:0]  band_hi;
   logic signed [LIM_W-1:0]  integ_l;
   logic signed [LIM_W-1:0]  integ_cl;
   logic signed [POS_W-1:0]  integ_c;
   logic signed [ERR_W-1:0]  err;

   always_comb begin
      restart    = mode_ff == MODE_RESTART;
      mask_r     = restart ? '0 : synced_ff;
      unsynced   = !mask_r[addr];
      if (unsynced) begin
         st_s.reference       = meas_ff;
         st_s.governed_target = meas_ff;
         st_s.integrator      = meas_ff;
      end else begin
         st_s = ram_rd_state;
      end
      case (mode_ff)
         MODE_NEW_REF: ref_n = tref_ff;
         MODE_HOLD:    ref_n = meas_ff;
         default:      ref_n = st_s.reference;
      endcase
      active_n   = (!restart && active_ff) || (mode_ff == MODE_NEW_REF)
                   || (mode_ff == MODE_HOLD);
      ready_sync = (!restart && cmd_ready_ff) || unsynced;
      ready_n    = ready_sync || active_n;
      mask_n     = mask_r | (JOINTS'(1) << addr);

      gs_s    = $signed(ERR_W'(cfg.governor_step));
      gt_diff = ERR_W'(ref_n) - ERR_W'(st_s.governed_target);
      if (gt_diff > gs_s) begin
         gt_move = gs_s;
      end else if (gt_diff < -gs_s) begin
         gt_move = -gs_s;
      end else begin
         gt_move = gt_diff;
      end
      gt_sum = ERR_W'(st_s.governed_target) + gt_move;
      gt_n   = gt_sum[POS_W-1:0];

      band     = (joint_ff >= NARROW_IDX) ? BAND_NARROW : BAND_WIDE;
      meas_l   = LIM_W'(meas_ff);
      band_lo  = meas_l - band;
      band_hi  = meas_l + band;
      integ_l  = LIM_W'(st_s.integrator);
      if (integ_l < band_lo) begin
         integ_cl = band_lo;
      end else if (integ_l > band_hi) begin
         integ_cl = band_hi;
      end else begin
         integ_cl = integ_l;
      end
      integ_c = integ_cl[POS_W-1:0];
      err     = ERR_W'(gt_n) - ERR_W'(integ_c);
   end

   // velocity: round, saturate, deadzone
   logic                     neg1;
   logic [PROD1_W-1:0]       mag1;
   logic [PROD1_W-1:0]       rnd1;
   logic [PROD1_W-1:0]       sat1;
   logic signed [POS_W-1:0]  qmag;
   logic signed [POS_W-1:0]  qdot;

   always_comb begin
      neg1 = prod1_ff < 0;
      mag1 = neg1 ? PROD1_W'(-prod1_ff) : PROD1_W'(prod1_ff);
      rnd1 = (mag1 + HALF1) >> FRAC_BITS;
      sat1 = (rnd1 > PROD1_W'(cfg.speed_cap)) ? PROD1_W'(cfg.speed_cap) : rnd1;
      if (sat1 < PROD1_W'(cfg.min_speed)) begin
         sat1 = '0;
      end
      qmag = $signed({1'b0, sat1[SPEED_W-1:0]});
      qdot = neg1 ? -qmag : qmag;
   end

   // step: round, step clamps, position clamps
   logic                     neg2;
   logic [PROD2_W-1:0]       mag2;
   logic [PROD2_W-1:0]       rnd2;
   logic [PROD2_W-1:0]       sat2;
   logic signed [DEL_W-1:0]  dmag;
   logic signed [DEL_W-1:0]  delta;
   logic signed [SUM_W-1:0]  ms_s;
   logic signed [SUM_W-1:0]  step_sum;
   logic signed [SUM_W-1:0]  rel;
   logic signed [SUM_W-1:0]  cmd_w;
   logic signed [SUM_W-1:0]  lo_w;
   logic signed [SUM_W-1:0]  hi_w;
   logic signed [POS_W-1:0]  cmd;

   always_comb begin
      neg2  = prod2_ff < 0;
      mag2  = neg2 ? PROD2_W'(-prod2_ff) : PROD2_W'(prod2_ff);
      rnd2  = (mag2 + HALF2) >> FRAC_BITS;
      sat2  = (rnd2 > PROD2_W'(cfg.cmd_step_cap)) ? PROD2_W'(cfg.cmd_step_cap) : rnd2;
      dmag  = $signed({1'b0, sat2[STEP_W-1:0]});
      delta = neg2 ? -dmag : dmag;

      ms_s     = $signed(SUM_W'(cfg.cmd_step_cap));
      step_sum = SUM_W'(integ_ff) + SUM_W'(delta) - SUM_W'(meas_ff);
      if (step_sum > ms_s) begin
         rel = ms_s;
      end else if (step_sum < -ms_s) begin
         rel = -ms_s;
      end else begin
         rel = step_sum;
      end
      cmd_w = SUM_W'(meas_ff) + rel;
      lo_w  = SUM_W'($signed(cfg.pos_low));
      hi_w  = SUM_W'($signed(cfg.pos_high));
      if (cmd_w < lo_w) begin
         cmd_w = lo_w;
      end
      if (cmd_w > hi_w) begin
         cmd_w = hi_w;
      end
      cmd = cmd_w[POS_W-1:0];
   end

   always_comb begin
      ram_wr_en = ((state_ff == ST_PREP) && in_range && !active_n)
                  || (state_ff == ST_FINISH);
      if (state_ff == ST_FINISH) begin
         ram_wr_state.reference       = ref_ff;
         ram_wr_state.governed_target = gt_ff;
         ram_wr_state.integrator      = cmd;
      end else begin
         ram_wr_state.reference       = ref_n;
         ram_wr_state.governed_target = st_s.governed_target;
         ram_wr_state.integrator      = st_s.integrator;
      end
   end

   assign req_chan.ready = state_ff == ST_IDLE;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         synced_ff    <= '0;
         active_ff    <= 1'b0;
         cmd_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  mode_ff  <= req_chan.word.mode;
                  joint_ff <= req_joint;
                  meas_ff  <= req_chan.word.measured_pos;
                  tref_ff  <= req_chan.word.target_ref;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (in_range) begin
                  synced_ff    <= mask_n;
                  active_ff    <= active_n;
                  cmd_ready_ff <= ready_n;
                  ref_ff       <= ref_n;
                  gt_ff        <= gt_n;
                  integ_ff     <= integ_c;
                  err_ff       <= err;
                  if (active_n) begin
                     state_ff <= ST_MUL1;
                  end else begin
                     res_cmd_ff   <= ready_sync ? st_s.integrator : '0;
                     res_valid_ff <= ready_sync;
                     state_ff     <= ST_OUT;
                  end
               end else begin
                  res_cmd_ff   <= '0;
                  res_valid_ff <= 1'b0;
                  state_ff     <= ST_OUT;
               end
            end
            ST_MUL1: begin
               prod1_ff <= err_ff * $signed({1'b0, cfg.follow_gain});
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               qdot_ff  <= qdot;
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               prod2_ff <= qdot_ff * $signed({1'b0, cfg.step_time});
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               res_cmd_ff   <= cmd;
               res_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_load) begin
                  rsp_word_ff.out_joint     <= joint_ff[JOINT_W-1:0];
                  rsp_word_ff.command_pos   <= res_cmd_ff;
                  rsp_word_ff.command_valid <= res_valid_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff) == ST_OUT)
      else $error("result word raised outside the output step");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_PREP)
      else $error("accepted tick did not start preparation");

   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> in_range)
      else $error("state RAM written for a joint out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.word.command_valid) |-> rsp_chan.word.command_pos == '0)
      else $error("command without validity carries a position");
`endif
endmodule
